// ===== rtl/ost_pkg.sv =====
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants of the order statistic set: field widths,
// operation and status codes, sequencer states and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package ost_pkg;

    localparam int OP_W    = 2;
    localparam int FIELD_W = 32;
    localparam int IDX_W   = 7;
    localparam int ST_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SELECT = 2'd2,
        OP_RANK   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic shift_in;
        logic shift_out;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/ost_in_if.sv =====
// ----------------------------------------------------------------------------
// ost_in_if
// Request channel of the order statistic set: one word carries an
// operation, a value and a 1-based index.
// ----------------------------------------------------------------------------
`default_nettype none

interface ost_in_if;
    import ost_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] value;
    logic [IDX_W-1:0]   index;

    modport source (output valid, output op, output value, output index, input ready);
    modport sink   (input valid, input op, input value, input index, output ready);
endinterface

`default_nettype wire

// ===== rtl/ost_out_if.sv =====
// ----------------------------------------------------------------------------
// ost_out_if
// Result channel of the order statistic set: one word carries a status,
// a selected value, a rank and the occupancy after the operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface ost_out_if;
    import ost_pkg::*;

    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [FIELD_W-1:0] found_value;
    logic [IDX_W-1:0]   position;
    logic [IDX_W-1:0]   occupancy;

    modport source (output valid, output status, output found_value, output position,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input found_value, input position,
                    input occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/ost_cell.sv =====
// ----------------------------------------------------------------------------
// ost_cell
// One slot of the sorted chain. It holds one value, registers whether that
// value lies below the operand and equals it, and on update keeps its value,
// takes the operand, or takes the value of its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire ost_pkg::t_cell_ctrl    i_ctrl,
    input  wire logic                   i_live,
    input  wire logic [VALUE_WIDTH-1:0] i_key,
    input  wire logic [VALUE_WIDTH-1:0] i_new,
    input  wire logic                   i_left_below,
    input  wire logic [VALUE_WIDTH-1:0] i_left_val,
    input  wire logic [VALUE_WIDTH-1:0] i_right_val,
    output logic [VALUE_WIDTH-1:0]      o_val,
    output logic                        o_below,
    output logic                        o_hit
);
    import ost_pkg::*;

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   r_below;
    logic                   r_eq;
    logic                   bnd;

    assign bnd = !r_below && i_left_below;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.shift_in && !r_below) begin
            n_val = bnd ? i_new : i_left_val;
        end else if (i_ctrl.shift_out && !r_below) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_ctrl.load) begin
            r_below <= i_live && ($signed(r_val) < $signed(i_key));
            r_eq    <= (r_val == i_key);
        end
    end

    assign o_val   = r_val;
    assign o_below = r_below;
    assign o_hit   = bnd && i_live && r_eq;

endmodule

`default_nettype wire

// ===== rtl/ost_reduce.sv =====
// ----------------------------------------------------------------------------
// ost_reduce
// Gathers the chain: turns the one-hot match of the cells into a found flag
// and a position, and picks the value of the one cell chosen for select.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_reduce #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int SEL_N       = 64,
    parameter int LO_W        = 6
) (
    input  wire logic [CAPACITY-1:0]                 i_hit,
    input  wire logic [SEL_N-1:0]                    i_sel,
    input  wire logic [SEL_N-1:0][VALUE_WIDTH-1:0]   i_vals,
    output logic                                     o_found,
    output logic [LO_W-1:0]                          o_lo,
    output logic [VALUE_WIDTH-1:0]                   o_sel_val
);
    import ost_pkg::*;

    always_comb begin
        o_lo = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_lo = o_lo | ({LO_W{i_hit[i]}} & LO_W'(i));
        end
    end

    always_comb begin
        o_sel_val = '0;
        for (int i = 0; i < SEL_N; i++) begin
            o_sel_val = o_sel_val | ({VALUE_WIDTH{i_sel[i]}} & i_vals[i]);
        end
    end

    assign o_found = |i_hit;

endmodule

`default_nettype wire

// ===== rtl/order_statistic_set.sv =====
// ----------------------------------------------------------------------------
// order_statistic_set
// Bounded sorted multiset of signed values with insert, delete, select by
// position and rank, built as a chain of cells that all shift together.
// ----------------------------------------------------------------------------
// In the cycle a word is accepted every cell compares its value with the
// operand and registers the result, and in the update state all cells shift
// together while the result word is registered. The update waits only while
// the previous result word is still held at the output. Values are kept in
// ascending order in a row of CAPACITY cells, and a rank over duplicate
// values reports the smallest of their positions.
`default_nettype none

module order_statistic_set #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ost_in_if.sink     i_in,
    ost_out_if.source  o_out
);
    import ost_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LO_W  = $clog2(CAPACITY);
    localparam int SEL_N = (CAPACITY < 127) ? CAPACITY : 127;
    localparam int CMP_W = CNT_W + IDX_W;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [OP_W-1:0]        r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic [FIELD_W-1:0]     r_fval, n_fval;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic [IDX_W-1:0]       r_occ, n_occ;

    logic [FIELD_W+VALUE_WIDTH-1:0] ext_in;
    logic [VALUE_WIDTH-1:0]         key_in;
    logic [VALUE_WIDTH+FIELD_W-1:0] ext_sel;
    t_cell_ctrl                     ctrl;

    logic [CAPACITY-1:0][VALUE_WIDTH-1:0] cell_val;
    logic [CAPACITY-1:0]                  cell_below;
    logic [CAPACITY-1:0]                  cell_hit;
    logic [CAPACITY-1:0]                  live;
    logic [SEL_N-1:0]                     sel;

    logic                   found;
    logic [LO_W-1:0]        lo;
    logic [VALUE_WIDTH-1:0] sel_val;
    logic                   full;
    logic                   sel_ok;

    assign ext_in  = {{VALUE_WIDTH{i_in.value[FIELD_W-1]}}, i_in.value};
    assign key_in  = ext_in[VALUE_WIDTH-1:0];
    assign ext_sel = {{FIELD_W{1'b0}}, sel_val};
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign sel_ok  = (r_idx != '0) && (CMP_W'(r_idx) <= CMP_W'(r_count));

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic                   left_below;
            logic [VALUE_WIDTH-1:0] left_val;
            logic [VALUE_WIDTH-1:0] right_val;

            assign live[i] = (r_count > CNT_W'(i));

            if (i == 0) begin : g_head
                assign left_below = 1'b1;
                assign left_val   = r_val;
            end else begin : g_body
                assign left_below = cell_below[i-1];
                assign left_val   = cell_val[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign right_val = cell_val[i];
            end else begin : g_inner
                assign right_val = cell_val[i+1];
            end

            if (i < SEL_N) begin : g_sel
                assign sel[i] = live[i] && (r_idx == IDX_W'(i + 1));
            end

            ost_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_live      (live[i]),
                .i_key       (key_in),
                .i_new       (r_val),
                .i_left_below(left_below),
                .i_left_val  (left_val),
                .i_right_val (right_val),
                .o_val       (cell_val[i]),
                .o_below     (cell_below[i]),
                .o_hit       (cell_hit[i])
            );
        end
    endgenerate

    ost_reduce #(
        .CAPACITY   (CAPACITY),
        .VALUE_WIDTH(VALUE_WIDTH),
        .SEL_N      (SEL_N),
        .LO_W       (LO_W)
    ) u_reduce (
        .i_hit    (cell_hit),
        .i_sel    (sel),
        .i_vals   (cell_val[SEL_N-1:0]),
        .o_found  (found),
        .o_lo     (lo),
        .o_sel_val(sel_val)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_fval      = r_fval;
        n_pos       = r_pos;
        n_occ       = r_occ;
        ctrl        = '0;
        ctrl.load   = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_fval      = '0;
                    n_pos       = '0;
                    unique case (t_op'(r_op))
                        OP_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ctrl.shift_in = 1'b1;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (found) begin
                                ctrl.shift_out = 1'b1;
                                n_count        = r_count - CNT_W'(1);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_SELECT: begin
                            if (sel_ok) begin
                                n_fval = ext_sel[FIELD_W-1:0];
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_RANK: begin
                            if (found) begin
                                n_pos = IDX_W'((LO_W + 1)'(lo) + (LO_W + 1)'(1));
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                    endcase
                    n_occ = IDX_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op  <= i_in.op;
            r_val <= key_in;
            r_idx <= i_in.index;
        end
        r_status <= n_status;
        r_fval   <= n_fval;
        r_pos    <= n_pos;
        r_occ    <= n_occ;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.found_value = r_fval;
    assign o_out.position    = r_pos;
    assign o_out.occupancy   = r_occ;

endmodule

`default_nettype wire

// ===== rtl/ost_checker.sv =====
// ----------------------------------------------------------------------------
// ost_checker
// Port-level checks of the order statistic set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ost_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [ost_pkg::ST_W-1:0]    i_status,
    input wire logic [ost_pkg::FIELD_W-1:0] i_found_value,
    input wire logic [ost_pkg::IDX_W-1:0]   i_position,
    input wire logic [ost_pkg::IDX_W-1:0]   i_occupancy
);
    import ost_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word shown right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request word taken while the previous one is in work");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_occupancy == IDX_W'(CAPACITY)))
        else $error("full status with a store that is not full");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_NOT_FOUND) |-> (i_position == '0) &&
        (i_found_value == '0))
        else $error("miss reported with a nonzero value or position");

endmodule

bind order_statistic_set ost_checker #(
    .CAPACITY(CAPACITY)
) u_ost_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_found_value(o_out.found_value),
    .i_position   (o_out.position),
    .i_occupancy  (o_out.occupancy)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the order statistic set. A shadow copy of the
// sorted contents predicts the answer to every accepted request word.
// Each result word is compared field by field with the oldest prediction.
// A short table of corner cases runs first, then about 550 random words.
// The random words move through growth, churn, fill-to-full, drain and mixed
// phases, while both channels pause at random outside the mixed phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ost_pkg::*;

    localparam int SET_DEPTH   = 64;
    localparam int RAND_WORDS  = 550;
    localparam int PHASE_LEN   = 110;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int OPEN_ROWS   = 25;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [FIELD_W-1:0] found;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   occ;
    } set_result_t;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] value;
        logic [IDX_W-1:0]   index;
        logic               typed;
        set_result_t        res;
    } opening_row_t;

    typedef struct packed {
        logic        typed;
        set_result_t res;
    } typed_answer_t;

    // Rows with typed answers can be read straight off the contents; the rest
    // fall back to the shadow set.
    localparam opening_row_t OPENING [OPEN_ROWS] = '{
        '{OP_SELECT, 32'h0000_0000, 7'd1,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd0}},
        '{OP_RANK,   32'h0000_0000, 7'd0,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd0}},
        '{OP_DELETE, 32'h0000_0005, 7'd0,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd0}},
        '{OP_INSERT, 32'h7FFF_FFFF, 7'd0,  1'b1, '{ST_OK, 32'h0, 7'd0, 7'd1}},
        '{OP_INSERT, 32'h8000_0000, 7'd0,  1'b1, '{ST_OK, 32'h0, 7'd0, 7'd2}},
        '{OP_INSERT, 32'h0000_0000, 7'd0,  1'b1, '{ST_OK, 32'h0, 7'd0, 7'd3}},
        '{OP_INSERT, 32'hFFFF_FFFF, 7'd0,  1'b0, '0},
        '{OP_INSERT, 32'hFFFF_FFFF, 7'd0,  1'b0, '0},
        '{OP_INSERT, 32'h0000_0007, 7'd0,  1'b0, '0},
        '{OP_SELECT, 32'h0000_0000, 7'd1,  1'b1, '{ST_OK, 32'h8000_0000, 7'd0, 7'd6}},
        '{OP_SELECT, 32'h0000_0000, 7'd6,  1'b1, '{ST_OK, 32'h7FFF_FFFF, 7'd0, 7'd6}},
        '{OP_SELECT, 32'h0000_0000, 7'd0,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd6}},
        '{OP_SELECT, 32'h0000_0000, 7'd7,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd6}},
        '{OP_SELECT, 32'h0000_0000, 7'd64, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd6}},
        '{OP_RANK,   32'hFFFF_FFFF, 7'd0,  1'b0, '0},
        '{OP_RANK,   32'h7FFF_FFFF, 7'd0,  1'b0, '0},
        '{OP_RANK,   32'h0000_0003, 7'd0,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd6}},
        '{OP_DELETE, 32'hFFFF_FFFF, 7'd0,  1'b0, '0},
        '{OP_RANK,   32'hFFFF_FFFF, 7'd0,  1'b0, '0},
        '{OP_DELETE, 32'h8000_0000, 7'd0,  1'b0, '0},
        '{OP_DELETE, 32'h8000_0000, 7'd0,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd4}},
        '{OP_SELECT, 32'h0000_0000, 7'd4,  1'b0, '0},
        '{OP_DELETE, 32'h7FFF_FFFF, 7'd0,  1'b0, '0},
        '{OP_INSERT, 32'h5555_5555, 7'd0,  1'b0, '0},
        '{OP_RANK,   32'hAAAA_AAAA, 7'd0,  1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0, 7'd4}}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ost_in_if  in_if ();
    ost_out_if out_if ();

    order_statistic_set #(
        .CAPACITY    (SET_DEPTH),
        .VALUE_WIDTH (FIELD_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    logic signed [FIELD_W-1:0] shadow_vals [SET_DEPTH];
    int                        shadow_n = 0;

    set_result_t   answers_due [$];
    typed_answer_t typed_answers [$];

    int  mismatches  = 0;
    int  n_sent      = 0;
    int  n_checked   = 0;
    int  n_full      = 0;
    int  n_missed    = 0;
    int  cycle_count = 0;
    bit  gaps_on     = 1'b1;
    bit  long_hold_req = 1'b0;

    function automatic set_result_t answer_for(t_op op, logic signed [FIELD_W-1:0] v,
                                               logic [IDX_W-1:0] ix);
        set_result_t r;
        int          below;
        r     = '0;
        below = 0;
        r.status = ST_OK;
        for (int i = 0; i < shadow_n; i++) begin
            if (shadow_vals[i] < v) below++;
        end
        case (op)
            OP_INSERT: begin
                if (shadow_n >= SET_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_n; i > below; i--) shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[below] = v;
                    shadow_n++;
                end
            end
            OP_DELETE: begin
                if (below < shadow_n && shadow_vals[below] == v) begin
                    for (int i = below; i + 1 < shadow_n; i++) shadow_vals[i] = shadow_vals[i+1];
                    shadow_n--;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_SELECT: begin
                if (ix >= 1 && int'(ix) <= shadow_n) begin
                    r.found = shadow_vals[int'(ix) - 1];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (below < shadow_n && shadow_vals[below] == v) begin
                    r.pos = IDX_W'(below + 1);
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
        endcase
        r.occ = IDX_W'(shadow_n);
        return r;
    endfunction

    function automatic t_op pick_op(int ins_pct, int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) return OP_INSERT;
        if (r < ins_pct + del_pct) return OP_DELETE;
        return r[0] ? OP_SELECT : OP_RANK;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value(int hit_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < hit_pct && shadow_n > 0) return shadow_vals[$urandom_range(0, shadow_n - 1)];
        r = $urandom_range(0, 9);
        if (r < 3) return $urandom_range(0, 16) - 8;
        if (r == 3) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int top;
        top = (shadow_n + 1 > SET_DEPTH) ? SET_DEPTH : shadow_n + 1;
        if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, top));
        return IDX_W'($urandom_range(0, SET_DEPTH));
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(t_op op, logic [FIELD_W-1:0] v, logic [IDX_W-1:0] ix,
                             typed_answer_t typed);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        typed_answers.push_back(typed);
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.value <= v;
        in_if.index <= ix;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        n_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        set_result_t   want;
        set_result_t   got;
        typed_answer_t typed;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.status, out_if.found_value, out_if.position, out_if.occupancy};
                if (answers_due.size() == 0) begin
                    $error("result word with no request pending");
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    n_checked++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.found !== want.found) begin
                        $error("found_value: expected %0d, got %0d",
                               $signed(want.found), $signed(got.found));
                        mismatches++;
                    end
                    if (got.pos !== want.pos) begin
                        $error("position: expected %0d, got %0d", want.pos, got.pos);
                        mismatches++;
                    end
                    if (got.occ !== want.occ) begin
                        $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
                        mismatches++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                want  = answer_for(t_op'(in_if.op), in_if.value, in_if.index);
                typed = typed_answers.pop_front();
                if (typed.typed) want = typed.res;
                if (want.status == ST_FULL) n_full++;
                if (want.status == ST_NOT_FOUND) n_missed++;
                answers_due.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int            phase;
        int            ins_pct [5];
        int            del_pct [5];
        int            hit_pct [5];
        t_op           op;
        typed_answer_t typed;
        ins_pct = '{65, 25, 85, 10, 30};
        del_pct = '{10, 25,  5, 70, 30};
        hit_pct = '{40, 50, 40, 80, 50};
        in_if.valid = 1'b0;
        in_if.op    = OP_INSERT;
        in_if.value = '0;
        in_if.index = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < OPEN_ROWS; r++) begin
            typed = '{OPENING[r].typed, OPENING[r].res};
            send_word(OPENING[r].op, OPENING[r].value, OPENING[r].index, typed);
        end

        for (int k = 0; k < RAND_WORDS; k++) begin
            phase = k / PHASE_LEN;
            if (k == 150) long_hold_req = 1'b1;
            if (phase == 4) gaps_on = 1'b0;
            op = pick_op(ins_pct[phase], del_pct[phase]);
            send_word(op, pick_value(hit_pct[phase]), pick_index(), '0);
        end
        in_if.valid <= 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words through growth, churn, fill, drain and mixed phases.", n_sent);
        $display("Checked %0d results: %0d refused as full, %0d not found or out of range.",
                 n_checked, n_full, n_missed);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
